>>> sv/lpf_pkg.sv
`default_nettype none

package lpf_pkg;

  // Width of the value being factored and of the returned factor.
  localparam int VALUE_WIDTH = 32;

  // Bits needed to count the steps of one division.
  localparam int CNT_W = $clog2(VALUE_WIDTH);

  // Width of the result bus: factor, then the invalid flag, padded to whole bytes.
  localparam int OUT_TDATA_W = ((VALUE_WIDTH + 1 + 7) / 8) * 8;

  // The first trial divisor.
  localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR = VALUE_WIDTH'(2);

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EVAL,
    ST_DONE
  } lpf_state_t;

endpackage

`default_nettype wire

>>> sv/largest_prime_factor_unit.sv
// Largest prime factor by trial division.
//
// Input channel (in_*): one item is a 32-bit unsigned number in in_tdata.
// Result channel (out_*): one item per input, out_tdata holds the factor in
// bits 31:0 and the invalid flag in bit 32. Numbers 0 and 1 have no prime
// factor; they return factor 0 with the invalid flag set.
//
// The block works on one item at a time and holds in_tready low from the
// moment an item is accepted until its result has been taken. Each trial
// goes through a shared restoring divider that produces one quotient bit per
// cycle, then through one evaluate step. An item needs one trial per divisor
// tried plus one per factor divided out. Invalid numbers go straight from
// idle to the result without a division.
//
// A synchronous active-low reset returns the sequencer to idle and drops
// out_tvalid. When the receiver stalls, the result stays in its output
// register with out_tvalid high, and no new item is accepted until it is taken.

`default_nettype none

module largest_prime_factor_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [lpf_pkg::VALUE_WIDTH-1:0]    in_tdata,   // [31:0] number
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [lpf_pkg::OUT_TDATA_W-1:0]         out_tdata   // [31:0] factor, [32] invalid
);
  import lpf_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

  lpf_state_t             state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] value_r, value_nxt;     // remaining value to factor
  logic [VALUE_WIDTH-1:0] div_r, div_nxt;         // current trial divisor
  logic [VALUE_WIDTH-1:0] quo_r, quo_nxt;         // dividend shifting out, quotient in
  logic [VALUE_WIDTH-1:0] part_r, part_nxt;       // partial remainder
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] factor_r, factor_nxt;
  logic                   invalid_r, invalid_nxt;

  // One restoring division step: shift in the next dividend bit and try to subtract.
  logic [VALUE_WIDTH:0] trial;
  logic [VALUE_WIDTH:0] diff;

  always_comb begin
    trial = {part_r, quo_r[VALUE_WIDTH-1]};
    diff  = trial - {1'b0, div_r};
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    value_r   <= value_nxt;
    div_r     <= div_nxt;
    quo_r     <= quo_nxt;
    part_r    <= part_nxt;
    cnt_r     <= cnt_nxt;
    factor_r  <= factor_nxt;
    invalid_r <= invalid_nxt;
  end

  // Sequencer: load, divide, evaluate the trial, present the result.
  always_comb begin
    state_nxt   = state_r;
    value_nxt   = value_r;
    div_nxt     = div_r;
    quo_nxt     = quo_r;
    part_nxt    = part_r;
    cnt_nxt     = cnt_r;
    factor_nxt  = factor_r;
    invalid_nxt = invalid_r;
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tdata < FIRST_DIVISOR) begin
            factor_nxt  = '0;
            invalid_nxt = 1'b1;
            state_nxt   = ST_DONE;
          end else begin
            value_nxt = in_tdata;
            div_nxt   = FIRST_DIVISOR;
            quo_nxt   = in_tdata;
            part_nxt  = '0;
            cnt_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        // A clear borrow bit means the divisor fit.
        if (!diff[VALUE_WIDTH]) begin
          part_nxt = diff[VALUE_WIDTH-1:0];
          quo_nxt  = {quo_r[VALUE_WIDTH-2:0], 1'b1};
        end else begin
          part_nxt = trial[VALUE_WIDTH-1:0];
          quo_nxt  = {quo_r[VALUE_WIDTH-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        // Divisor squared above the value means the value itself is prime.
        if (div_r > quo_r) begin
          factor_nxt  = value_r;
          invalid_nxt = 1'b0;
          state_nxt   = ST_DONE;
        end else begin
          if (part_r == '0) begin
            // Divide the factor out and retry the same divisor.
            value_nxt = quo_r;
            quo_nxt   = quo_r;
          end else begin
            div_nxt = div_r + VALUE_WIDTH'(1);
            quo_nxt = value_r;
          end
          part_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end

      ST_DONE: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tdata = {(OUT_TDATA_W - VALUE_WIDTH - 1)'(0), invalid_r, factor_r};

  // The block never takes an item while a result is pending.
  assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("input accepted while a result is pending");

  // An invalid result always carries a zero factor.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && invalid_r) |-> (factor_r == '0))
    else $error("invalid result with nonzero factor");

  // Trial divisors never drop below the first divisor.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> (div_r >= FIRST_DIVISOR))
    else $error("trial divisor below two");

  // After a full division the remainder is below the divisor.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> (part_r < div_r))
    else $error("division remainder not below divisor");

  // A valid result is never smaller than the first divisor.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !invalid_r) |-> (factor_r >= FIRST_DIVISOR))
    else $error("valid result below two");

endmodule

`default_nettype wire
